// ===== rtl/heat_diffusion_stencil_solver_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef HEAT_DIFFUSION_STENCIL_SOLVER_UNIT_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define HDSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define HDSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define HDSS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hdss_pkg.sv =====
`default_nettype none
package hdss_pkg;

  localparam int VALUE_BITS     = 20;
  localparam int FRAC_BITS      = 16;
  localparam int STEP_W         = 20;
  localparam int NP_W           = 9;
  localparam int IDX_W          = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_W          = 20;
  localparam int S_TDATA_W      = 16;
  localparam int M_FIELDS_W     = 2 * VALUE_BITS + STEP_W + 1;
  localparam int M_TDATA_W      = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W        = M_TDATA_W - M_FIELDS_W;
  localparam int MAX_POINTS_DEF = 256;

  localparam logic [VALUE_BITS-1:0] LEFT_END  = VALUE_BITS'(1 << FRAC_BITS);
  localparam logic [VALUE_BITS-1:0] RIGHT_END = VALUE_BITS'(10 << FRAC_BITS);

  localparam logic [NP_W-1:0]   NUM_POINTS_RST = NP_W'(256);
  localparam logic [STEP_W-1:0] MAX_STEPS_RST  = STEP_W'(1000);
  localparam logic [VALUE_BITS-1:0] THRESH_RST = VALUE_BITS'(7);

  localparam logic CMD_RUN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_POINTS = 2'd0,
    CFG_MAX_STEPS  = 2'd1,
    CFG_THRESHOLD  = 2'd2
  } hdss_cfg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic start_run;     // load point count, clear counters, start init pass
    logic start_sweep;   // start one stencil pass
    logic finish;        // commit run status
    logic read_issue;    // present read address to the grid
    logic read_capture;  // latch read data
  } hdss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pass_done;
    logic keep_going;
  } hdss_sts_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] max_change;
    logic                  converged;
    logic [STEP_W-1:0]     steps_taken;
    logic [VALUE_BITS-1:0] point_value;
  } hdss_res_t;

endpackage
`default_nettype wire

// ===== rtl/hdss_ctrl.sv =====
`default_nettype none
module hdss_ctrl
  import hdss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_cmd,
  output logic           in_ready,
  input  wire hdss_sts_t sts,
  input  wire logic      out_free,
  output hdss_cmd_t      cmd,
  output logic           result_load
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_INIT   = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_SWEEP  = 7'b0001000,
    ST_FINISH = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    result_load = 1'b0;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_RUN) begin
            cmd.start_run = 1'b1;
            state_next    = ST_INIT;
          end else begin
            cmd.read_issue = 1'b1;
            state_next     = ST_READ;
          end
        end
      end
      ST_INIT: begin
        if (sts.pass_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.keep_going) begin
          cmd.start_sweep = 1'b1;
          state_next      = ST_SWEEP;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (sts.pass_done) state_next = ST_CHECK;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_RESULT;
      end
      ST_READ: begin
        cmd.read_capture = 1'b1;
        state_next       = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/hdss_dp.sv =====
`default_nettype none
module hdss_dp
  import hdss_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [NP_W-1:0]       num_points,
  input  wire logic [STEP_W-1:0]     max_steps,
  input  wire logic [VALUE_BITS-1:0] threshold,
  input  wire logic [IDX_W-1:0]      point_index,
  input  wire hdss_cmd_t             cmd,
  output hdss_sts_t                  sts,
  output hdss_res_t                  res
);

  localparam int DEPTH  = MAX_POINTS + 2;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = ((ADDR_W > NP_W) ? ADDR_W : NP_W) + 1;
  localparam int SW     = VALUE_BITS + 3;

  // two grid buffers; sel names the one holding the current values
  logic [VALUE_BITS-1:0] bank0 [DEPTH];
  logic [VALUE_BITS-1:0] bank1 [DEPTH];
  logic [VALUE_BITS-1:0] q0, q1, dat;

  logic [ADDR_W-1:0]     n_pts, run_pts, cnt, last_addr, raddr, waddr, rd_idx, e_addr;
  logic [STEP_W-1:0]     step;
  logic [VALUE_BITS-1:0] md, md_acc, md_new;
  logic                  sel, ran, init_act, issue, rd_vld, e_vld, rv, pass_done;
  logic [VALUE_BITS-1:0] w_l, w_c, e_nv, e_d, wdata, init_val;
  logic                  we0, we1;
  logic [CMP_W-1:0]      np_ext, n_clamp, idx_ext;

  logic [STEP_W-1:0]     sweep_count;
  logic [VALUE_BITS-1:0] largest_change, res_pv;
  logic                  conv;

  logic signed [SW-1:0]  l_s, c_s, r_s, lap, half, nv_s;
  logic [VALUE_BITS-1:0] nv, dv;
  logic                  stencil_vld;

  assign last_addr = n_pts + ADDR_W'(1);
  assign np_ext    = CMP_W'(num_points);
  assign n_clamp   = (np_ext == '0) ? CMP_W'(1) :
                     (np_ext > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS) : np_ext;
  assign idx_ext   = CMP_W'(point_index);

  assign init_val  = (cnt == '0) ? LEFT_END : (cnt == last_addr) ? RIGHT_END : '0;

  // grid ports
  assign raddr = cmd.read_issue ? idx_ext[ADDR_W-1:0] : cnt;
  assign waddr = init_act ? cnt : e_addr;
  assign wdata = init_act ? init_val : e_nv;
  assign we0   = init_act | (e_vld & sel);
  assign we1   = init_act | (e_vld & ~sel);

  always_ff @(posedge clk) begin
    if (we0) bank0[waddr] <= wdata;
    if (we1) bank1[waddr] <= wdata;
    q0 <= bank0[raddr];
    q1 <= bank1[raddr];
  end

  assign dat = sel ? q1 : q0;

  // three-point stencil on the window (w_l, w_c, dat)
  assign stencil_vld = rd_vld && (rd_idx >= ADDR_W'(2));
  always_comb begin
    l_s  = signed'(SW'(w_l));
    c_s  = signed'(SW'(w_c));
    r_s  = signed'(SW'(dat));
    lap  = r_s + l_s - (c_s <<< 1);
    half = lap >>> 1;
    nv_s = c_s + half;
    nv   = nv_s[SW-1] ? '0 : nv_s[VALUE_BITS-1:0];
    dv   = (w_c >= nv) ? (w_c - nv) : (nv - w_c);
  end

  assign md_new = (e_d > md_acc) ? e_d : md_acc;

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      w_l <= w_c;
      w_c <= dat;
    end
    e_addr <= rd_idx - ADDR_W'(1);
    e_nv   <= nv;
    e_d    <= dv;
    rd_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_act  <= 1'b0;
      issue     <= 1'b0;
      rd_vld    <= 1'b0;
      e_vld     <= 1'b0;
      pass_done <= 1'b0;
      sel       <= 1'b0;
      ran       <= 1'b0;
      n_pts     <= '0;
      run_pts   <= '0;
      cnt       <= '0;
      step      <= '0;
      md        <= '0;
      md_acc    <= '0;
      rv        <= 1'b0;
      sweep_count    <= '0;
      largest_change <= '0;
      conv           <= 1'b0;
      res_pv         <= '0;
    end else begin
      pass_done <= 1'b0;
      rd_vld    <= issue;
      e_vld     <= stencil_vld;

      if (cmd.start_run) begin
        n_pts    <= n_clamp[ADDR_W-1:0];
        step     <= '0;
        md       <= threshold;
        sel      <= 1'b0;
        cnt      <= '0;
        init_act <= 1'b1;
      end else if (init_act) begin
        if (cnt == last_addr) begin
          init_act  <= 1'b0;
          pass_done <= 1'b1;
        end else begin
          cnt <= cnt + ADDR_W'(1);
        end
      end

      if (cmd.start_sweep) begin
        cnt    <= '0;
        issue  <= 1'b1;
        md_acc <= '0;
      end else if (issue) begin
        if (cnt == last_addr) begin
          issue <= 1'b0;
        end else begin
          cnt <= cnt + ADDR_W'(1);
        end
      end

      if (e_vld) begin
        md_acc <= md_new;
        if (e_addr == n_pts) begin
          md        <= md_new;
          sel       <= ~sel;
          pass_done <= 1'b1;
          // a sweep that changes nothing under a zero threshold would otherwise repeat until max_steps
          if ((md_new == '0) && (threshold == '0)) begin
            step <= max_steps;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
      end

      if (cmd.finish) begin
        run_pts        <= n_pts;
        ran            <= 1'b1;
        sweep_count    <= step;
        largest_change <= md;
        conv           <= (md < threshold);
        res_pv         <= '0;
      end

      if (cmd.read_issue) begin
        rv <= ran && (idx_ext <= (CMP_W'(run_pts) + CMP_W'(1)));
      end
      if (cmd.read_capture) begin
        res_pv <= rv ? dat : '0;
      end
    end
  end

  assign sts.pass_done  = pass_done;
  assign sts.keep_going = (step < max_steps) && (md >= threshold);

  assign res.point_value = res_pv;
  assign res.steps_taken = sweep_count;
  assign res.converged   = conv;
  assign res.max_change  = largest_change;

endmodule
`default_nettype wire

// ===== rtl/heat_diffusion_stencil_solver_unit.sv =====
// Explicit 1-D heat solver (Jacobi sweeps) on a rod of num_points interior
// points with ends fixed at 1.0 and 10.0, values unsigned Q4.16.
// Input stream: s_tuser selects the command (run or read one point),
// s_tdata carries the point index for reads. One result item per input item
// leaves on the m_ stream: point value (zero for runs), sweep count,
// converged flag and largest change of the final sweep of the last run.
// Configuration: cfg_we/cfg_index/cfg_data write num_points, max_steps and
// threshold; write them only while no item is in flight.
// Sequence: a read passes the READ and RESULT states before m_tvalid. A run
// first lays down the initial grid, ends included, then runs its sweeps;
// a sweep walks the grid one point per cycle through a single read port of
// the current buffer.
// One item is worked on at a time; s_tready is high only when idle.
// Reset clears the controller, the run status and the output valid flag; the
// grid buffers are not cleared, reads before the first run return zero.
// When the receiver stalls the result holds in the output register; the
// controller waits with it and takes no new item until the register frees.
`default_nettype none
module heat_diffusion_stencil_solver_unit
  import hdss_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic                 s_tuser,   // [0] cmd
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // [8:0] point_index, rest zero
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [19:0] point_value, [39:20] steps_taken, [40] converged,
  // [60:41] max_change, [63:61] zero
  output logic [M_TDATA_W-1:0]      m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [NP_W-1:0]       num_points;
  logic [STEP_W-1:0]     max_steps;
  logic [VALUE_BITS-1:0] threshold;

  hdss_cmd_t cmd;
  hdss_sts_t sts;
  hdss_res_t res;
  logic      result_load;
  logic      out_free;

  // configuration registers; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NUM_POINTS_RST;
      max_steps  <= MAX_STEPS_RST;
      threshold  <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_POINTS: num_points <= cfg_data[NP_W-1:0];
        CFG_MAX_STEPS:  max_steps  <= cfg_data[STEP_W-1:0];
        CFG_THRESHOLD:  threshold  <= cfg_data[VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  hdss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_cmd      (s_tuser),
    .in_ready    (s_tready),
    .sts         (sts),
    .out_free    (out_free),
    .cmd         (cmd),
    .result_load (result_load)
  );

  hdss_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .num_points  (num_points),
    .max_steps   (max_steps),
    .threshold   (threshold),
    .point_index (s_tdata[IDX_W-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .res         (res)
  );

  // output register: load when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      m_tdata <= {M_PAD_W'(0), res.max_change, res.converged,
                  res.steps_taken, res.point_value};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hdss_checker.sv =====
`default_nettype none
`include "heat_diffusion_stencil_solver_unit_defines.svh"
module hdss_checker
  import hdss_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // stalled result holds
  `HDSS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // one item at a time: the input closes right after an accept
  `HDSS_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready, "input still open after accept")

  // the new grid value is a floor average of values within the rod's range; pad bits stay zero
  `HDSS_ASSERT_NOW(a_value_range, clk, rst, m_tvalid, (m_tdata[VALUE_BITS-1:0] <= RIGHT_END) && (m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0), "point value out of range")

  // no result straight out of reset
  `HDSS_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !m_tvalid, "result valid after reset")

endmodule

bind heat_diffusion_stencil_solver_unit hdss_checker u_hdss_checker (.*);
`default_nettype wire
